// ===== rtl/core/tun_pkg.sv =====
// Shared widths and beat types of the triangle unit normal block.
`timescale 1ns / 1ps

package tun_pkg;

   localparam int COORD_BITS     = 16;
   localparam int NORM_FRAC_BITS = 14;
   localparam int NORM_W         = NORM_FRAC_BITS + 2;
   localparam int DIFF_W         = COORD_BITS + 1;
   localparam int PROD_W         = 2 * DIFF_W;
   localparam int CROSS_W        = PROD_W + 1;
   localparam int MAG_W          = CROSS_W - 2;
   localparam int NORM_BITS      = 31;
   localparam int EXT_W          = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
   localparam int LZ_W           = $clog2(EXT_W + 1);
   localparam int SQ_W           = 2 * NORM_BITS;
   localparam int SUM_W          = SQ_W + 2;
   localparam int ROOT_W         = SUM_W / 2;
   localparam int REM_W          = SUM_W + 1;
   localparam int NUM_W          = NORM_BITS + NORM_FRAC_BITS + 1;
   localparam int QUO_W          = NORM_FRAC_BITS + 1;
   localparam int DREM_W         = ROOT_W + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
   } tun_req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
      logic                     degenerate;
   } tun_rsp_type;

   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } tun_cross_type;

   typedef struct packed {
      logic                      degenerate;
      logic [2:0]                neg;
      logic [2:0][NORM_BITS-1:0] u;
   } tun_side_type;

   typedef struct packed {
      logic       degenerate;
      logic [2:0] neg;
   } tun_sign_type;

endpackage

// ===== rtl/core/tun_cross.sv =====
// Edge differences, products and cross product magnitudes in three stages.
`timescale 1ns / 1ps

module tun_cross import tun_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  tun_req_type   in_data,
   output logic          out_valid,
   output tun_cross_type out_data
);

   logic signed [DIFF_W-1:0] u_in [3];
   logic signed [DIFF_W-1:0] v_in [3];
   logic signed [DIFF_W-1:0] u_ff [3];
   logic signed [DIFF_W-1:0] v_ff [3];
   logic signed [PROD_W-1:0] p_in [6];
   logic signed [PROD_W-1:0] p_ff [6];
   tun_cross_type            c_in;
   tun_cross_type            c_ff;
   logic                     v1_ff;
   logic                     v2_ff;
   logic                     v3_ff;

   always_comb begin
      u_in[0] = DIFF_W'(in_data.bx) - DIFF_W'(in_data.ax);
      u_in[1] = DIFF_W'(in_data.by_coord) - DIFF_W'(in_data.ay);
      u_in[2] = DIFF_W'(in_data.bz) - DIFF_W'(in_data.az);
      v_in[0] = DIFF_W'(in_data.cx) - DIFF_W'(in_data.ax);
      v_in[1] = DIFF_W'(in_data.cy) - DIFF_W'(in_data.ay);
      v_in[2] = DIFF_W'(in_data.cz) - DIFF_W'(in_data.az);
   end

   always_comb begin
      p_in[0] = v_ff[1] * u_ff[2];
      p_in[1] = u_ff[1] * v_ff[2];
      p_in[2] = v_ff[2] * u_ff[0];
      p_in[3] = u_ff[2] * v_ff[0];
      p_in[4] = v_ff[0] * u_ff[1];
      p_in[5] = u_ff[0] * v_ff[1];
   end

   always_comb begin
      logic signed [CROSS_W-1:0] n;
      logic        [CROSS_W-1:0] a;
      for (int i = 0; i < 3; i++) begin
         n = CROSS_W'(p_ff[2*i]) - CROSS_W'(p_ff[2*i+1]);
         a = n[CROSS_W-1] ? -n : n;
         c_in.neg[i] = n[CROSS_W-1];
         c_in.mag[i] = a[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff <= u_in;
         v_ff <= v_in;
         p_ff <= p_in;
         c_ff <= c_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = c_ff;

endmodule

// ===== rtl/core/tun_norm.sv =====
// Leading zero count, normalizing shift, squares and their sum in four stages.
`timescale 1ns / 1ps

module tun_norm import tun_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  tun_cross_type      in_data,
   output logic               out_valid,
   output tun_side_type       out_side,
   output logic [SUM_W-1:0]   out_sum
);

   logic [EXT_W-1:0]  orw;
   logic [LZ_W-1:0]   lz_in;
   logic [LZ_W-1:0]   lz_ff;
   logic              deg_ff;
   tun_cross_type     c1_ff;
   tun_side_type      s2_in;
   tun_side_type      s2_ff;
   tun_side_type      s3_ff;
   tun_side_type      s4_ff;
   logic [SQ_W-1:0]   sq_in [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [3:0]        v_ff;

   // The bit length of the largest magnitude equals that of their OR.
   always_comb begin
      orw   = EXT_W'(in_data.mag[0] | in_data.mag[1] | in_data.mag[2]);
      lz_in = LZ_W'(EXT_W);
      for (int i = 0; i < EXT_W; i++) begin
         if (orw[i]) begin
            lz_in = LZ_W'(EXT_W - 1 - i);
         end
      end
   end

   always_comb begin
      logic [EXT_W-1:0] ext;
      s2_in.degenerate = deg_ff;
      s2_in.neg        = c1_ff.neg;
      for (int i = 0; i < 3; i++) begin
         ext        = EXT_W'(c1_ff.mag[i]) << lz_ff;
         s2_in.u[i] = ext[EXT_W-1 -: NORM_BITS];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(s2_ff.u[i]) * SQ_W'(s2_ff.u[i]);
      end
      sum_in = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lz_ff  <= lz_in;
         deg_ff <= (orw == '0);
         c1_ff  <= in_data;
         s2_ff  <= s2_in;
         s3_ff  <= s2_ff;
         sq_ff  <= sq_in;
         s4_ff  <= s3_ff;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_side  = s4_ff;
   assign out_sum   = sum_ff;

endmodule

// ===== rtl/core/tun_sqrt.sv =====
// Integer square root, one result bit per pipeline stage.
`timescale 1ns / 1ps

module tun_sqrt import tun_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  tun_side_type       in_side,
   input  logic [SUM_W-1:0]   in_sum,
   output logic               out_valid,
   output tun_side_type       out_side,
   output logic [ROOT_W-1:0]  out_root
);

   logic                v_ff    [ROOT_W];
   tun_side_type        side_ff [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int B = ROOT_W - 1 - k;
      logic              v_i;
      tun_side_type      side_i;
      logic [REM_W-1:0]  rem_i;
      logic [ROOT_W-1:0] root_i;
      logic [REM_W-1:0]  trial;
      logic              take;

      if (k == 0) begin : g_first
         assign v_i    = in_valid;
         assign side_i = in_side;
         assign rem_i  = REM_W'(in_sum);
         assign root_i = '0;
      end else begin : g_next
         assign v_i    = v_ff[k-1];
         assign side_i = side_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
      end

      // Growing the root by bit B raises its square by root*2^(B+1) + 4^B.
      assign trial = (REM_W'(root_i) << (B + 1)) + (REM_W'(1) << (2 * B));
      assign take  = (rem_i >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_i;
            rem_ff[k]  <= take ? rem_i - trial : rem_i;
            root_ff[k] <= take ? (root_i | (ROOT_W'(1) << B)) : root_i;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

// ===== rtl/core/tun_div.sv =====
// Rounded division of three lanes by the length, one quotient bit per stage after the first.
`timescale 1ns / 1ps

module tun_div import tun_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  tun_side_type          in_side,
   input  logic [ROOT_W-1:0]     in_root,
   output logic                  out_valid,
   output tun_sign_type          out_sign,
   output logic [2:0][QUO_W-1:0] out_quo
);

   logic [NUM_W-1:0]   num_in [3];
   logic [NUM_W-1:0]   num_ff [3];
   logic [ROOT_W-1:0]  r0_ff;
   tun_sign_type       s0_ff;
   logic               v0_ff;

   logic               v_ff   [QUO_W];
   tun_sign_type       s_ff   [QUO_W];
   logic [ROOT_W-1:0]  r_ff   [QUO_W];
   logic [DREM_W-1:0]  rem_ff [QUO_W][3];
   logic [QUO_W-1:0]   low_ff [QUO_W][3];
   logic [QUO_W-1:0]   q_ff   [QUO_W][3];

   // Adding half the divisor makes the truncating quotient round to nearest.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_W'(in_side.u[i]) << NORM_FRAC_BITS) + NUM_W'(in_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff           <= num_in;
         r0_ff            <= in_root;
         s0_ff.degenerate <= in_side.degenerate;
         s0_ff.neg        <= in_side.neg;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int J = QUO_W - 1 - k;
      logic              v_i;
      tun_sign_type      s_i;
      logic [ROOT_W-1:0] r_i;
      logic [DREM_W-1:0] rem_i [3];
      logic [QUO_W-1:0]  low_i [3];
      logic [QUO_W-1:0]  q_i   [3];

      if (k == 0) begin : g_first
         assign v_i = v0_ff;
         assign s_i = s0_ff;
         assign r_i = r0_ff;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_i[i] = DREM_W'(num_ff[i][NUM_W-1:QUO_W]);
            assign low_i[i] = num_ff[i][QUO_W-1:0];
            assign q_i[i]   = '0;
         end
      end else begin : g_next
         assign v_i = v_ff[k-1];
         assign s_i = s_ff[k-1];
         assign r_i = r_ff[k-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_i[i] = rem_ff[k-1][i];
            assign low_i[i] = low_ff[k-1][i];
            assign q_i[i]   = q_ff[k-1][i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_i;
         end
      end

      for (genvar i = 0; i < 3; i++) begin : g_unit
         logic [DREM_W-1:0] t;
         logic              ge;
         assign t  = {rem_i[i][ROOT_W-1:0], low_i[i][J]};
         assign ge = (t >= DREM_W'(r_i));

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][i] <= ge ? t - DREM_W'(r_i) : t;
               low_ff[k][i] <= low_i[i];
               q_ff[k][i]   <= q_i[i] | (QUO_W'(ge) << J);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff[k] <= s_i;
            r_ff[k] <= r_i;
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_sign  = s_ff[QUO_W-1];
   for (genvar i = 0; i < 3; i++) begin : g_out
      assign out_quo[i] = q_ff[QUO_W-1][i];
   end

endmodule

// ===== rtl/core/triangle_unit_normal.sv =====
// Top level of the triangle unit normal pipeline.
`timescale 1ns / 1ps

// The block takes one triangle per beat on the req_ channel (three corners,
// nine signed 16-bit coordinates) and returns its unit face normal on the
// rsp_ channel as three signed Q1.14 components and a degenerate flag.
// The normal is the cross product (c - a) x (b - a), normalized to a length
// of one with round to nearest. When the cross product is zero the flag is
// set and all three components are zero.
// Every triangle gives exactly one result beat, in order.
// From an accepted request beat to the result beat, three stages form the
// cross product, four normalize and square it, 32 produce the square root
// one bit per stage, 16 divide with one quotient bit in each stage after
// the first, and one output register drives rsp_.
// Throughput is one triangle per cycle while the pipeline is not held, and
// every stage is a pipeline register. The whole pipeline advances together.
// It holds only while a result beat waits on rsp_ and rsp_stall is high;
// req_stall is then high too, and no beat in flight is lost or repeated.
// Empty slots between beats travel as bubbles and cost nothing.
// A synchronous reset clears every valid bit; no result beat follows it.
module triangle_unit_normal import tun_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tun_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tun_rsp_type rsp_data
);

   logic                  adv;
   logic                  cr_valid;
   tun_cross_type         cr_data;
   logic                  nm_valid;
   tun_side_type          nm_side;
   logic [SUM_W-1:0]      nm_sum;
   logic                  sq_valid;
   tun_side_type          sq_side;
   logic [ROOT_W-1:0]     sq_root;
   logic                  dv_valid;
   tun_sign_type          dv_sign;
   logic [2:0][QUO_W-1:0] dv_quo;
   logic                  rsp_valid_ff;
   tun_rsp_type           rsp_data_ff;
   tun_rsp_type           rsp_data_in;

   // All stages move while the output register is empty or being taken.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   tun_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (cr_valid),
      .out_data  (cr_data)
   );

   tun_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cr_valid),
      .in_data   (cr_data),
      .out_valid (nm_valid),
      .out_side  (nm_side),
      .out_sum   (nm_sum)
   );

   tun_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (nm_valid),
      .in_side   (nm_side),
      .in_sum    (nm_sum),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   tun_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_side   (sq_side),
      .in_root   (sq_root),
      .out_valid (dv_valid),
      .out_sign  (dv_sign),
      .out_quo   (dv_quo)
   );

   // Apply the component signs, and force a zero normal for a degenerate
   // triangle, whose divider lanes carry meaningless quotients.
   always_comb begin
      logic [NORM_W-1:0] comp [3];
      logic [NORM_W-1:0] m;
      for (int i = 0; i < 3; i++) begin
         m       = NORM_W'(dv_quo[i]);
         comp[i] = dv_sign.degenerate ? '0 : (dv_sign.neg[i] ? -m : m);
      end
      rsp_data_in.norm_x     = comp[0];
      rsp_data_in.norm_y     = comp[1];
      rsp_data_in.norm_z     = comp[2];
      rsp_data_in.degenerate = dv_sign.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/triangle_unit_normal_test.sv =====
// Self-checking bench for the triangle unit normal pipeline.
`timescale 1ns / 1ps

module triangle_unit_normal_test;
   import tun_pkg::*;

   localparam int LATENCY    = 56;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_CNT = 1100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   tun_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   tun_rsp_type rsp_data;

   triangle_unit_normal dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Triangles waiting to be driven, and normals expected back in order.
   tun_req_type triangle_queue[$];
   tun_rsp_type normal_queue[$];

   int  error_count;
   int  idle_cycles;
   bit  stimulus_done;
   int  send_wait;
   int  recv_wait;

   initial begin
      clock = 1'b0;
      forever begin
         #4 clock = 1'b1;
         #4 clock = 1'b0;
      end
   end

   // Appends one triangle to the stimulus queue.
   task automatic add_triangle(input tun_req_type t);
      triangle_queue = {triangle_queue, t};
   endtask

   // Integer square root by the bit-pair method, 64-bit operand.
   function automatic logic [63:0] root_floor(input logic [63:0] s_in);
      logic [63:0] s;
      logic [63:0] root;
      logic [63:0] b;
      s    = s_in;
      root = 64'd0;
      b    = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 64'd0) begin
         if (s >= root + b) begin
            s    = s - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Computes the expected unit normal of one triangle.
   function automatic tun_rsp_type face_normal(input tun_req_type t);
      logic signed [63:0] ex, ey, ez, fx, fy, fz;
      logic signed [63:0] n[3];
      logic [63:0]        u[3];
      logic [63:0]        m, s, r, q;
      int                 len;
      tun_rsp_type        res;
      ex = 64'(t.bx) - 64'(t.ax);
      ey = 64'(t.by_coord) - 64'(t.ay);
      ez = 64'(t.bz) - 64'(t.az);
      fx = 64'(t.cx) - 64'(t.ax);
      fy = 64'(t.cy) - 64'(t.ay);
      fz = 64'(t.cz) - 64'(t.az);
      n[0] = fy * ez - ey * fz;
      n[1] = fz * ex - ez * fx;
      n[2] = fx * ey - ex * fy;
      m = 64'd0;
      for (int i = 0; i < 3; i++) begin
         u[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
         if (u[i] > m) m = u[i];
      end
      res = '0;
      if (m == 64'd0) begin
         res.degenerate = 1'b1;
         return res;
      end
      len = 0;
      while (m != 64'd0) begin
         len++;
         m = m >> 1;
      end
      for (int i = 0; i < 3; i++) begin
         if (len > NORM_BITS) u[i] = u[i] >> (len - NORM_BITS);
         else if (len < NORM_BITS) u[i] = u[i] << (NORM_BITS - len);
      end
      s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      r = root_floor(s);
      for (int i = 0; i < 3; i++) begin
         q = ((u[i] << NORM_FRAC_BITS) + (r >> 1)) / r;
         if (n[i] < 0) q = 64'd0 - q;
         case (i)
            0: res.norm_x = q[NORM_W-1:0];
            1: res.norm_y = q[NORM_W-1:0];
            default: res.norm_z = q[NORM_W-1:0];
         endcase
      end
      return res;
   endfunction

   function automatic tun_req_type make_triangle(
      input int x0, input int y0, input int z0,
      input int x1, input int y1, input int z1,
      input int x2, input int y2, input int z2);
      tun_req_type t;
      t.ax = x0[15:0]; t.ay = y0[15:0]; t.az = z0[15:0];
      t.bx = x1[15:0]; t.by_coord = y1[15:0]; t.bz = z1[15:0];
      t.cx = x2[15:0]; t.cy = y2[15:0]; t.cz = z2[15:0];
      return t;
   endfunction

   // A coordinate drawn wide, small, or at an extreme, so that cross products
   // of every bit length occur.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 15) - 8);
         1: return 16'($urandom_range(0, 511) - 256);
         2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      tun_req_type t;
      int          base;
      // Extremes, axis-aligned faces, both windings and degenerate shapes.
      add_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_triangle(make_triangle(5, 5, 5, 5, 5, 5, 5, 5, 5));
      add_triangle(make_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2));
      add_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      add_triangle(make_triangle(0, 0, 0, 0, 1, 0, 1, 0, 0));
      add_triangle(make_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1));
      add_triangle(make_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0));
      add_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 0, 1));
      add_triangle(make_triangle(0, 0, 0, 1, 0, 0, 1, 1, 1));
      add_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768,
                                 -32768, -32768, 32767, -32768));
      add_triangle(make_triangle(32767, 32767, 32767, -32768, 32767,
                                 32767, 32767, -32768, 32767));
      add_triangle(make_triangle(-32768, 32767, -32768, 32767, -32768,
                                 32767, 32767, 32767, -32768));
      add_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767,
                                 32767, 0, 0, 0));
      add_triangle(make_triangle(0, 0, 0, 32767, 1, 0, 0, 1, 1));
      add_triangle(make_triangle(0, 0, 0, 1, 0, 0, 1, 32767, 0));
      add_triangle(make_triangle(-1, -1, -1, 0, 0, 0, -1, 0, -1));
      add_triangle(make_triangle(0, 0, 0, 3, 0, 0, 0, 4, 0));
      add_triangle(make_triangle(0, 0, 0, 1, 1, 0, 0, 0, 1));
      add_triangle(make_triangle(-32768, 0, 0, 32767, 0, 0, 0, 0, 1));
      for (int i = 0; i < RANDOM_CNT; i++) begin
         t.ax = pick_coord(); t.ay = pick_coord(); t.az = pick_coord();
         case ($urandom_range(0, 7))
            0: begin
               // Local triangle around a random anchor: small edges.
               base = $urandom_range(0, 63);
               t.bx = t.ax + 16'($urandom_range(0, 2 * base) - base);
               t.by_coord = t.ay + 16'($urandom_range(0, 2 * base) - base);
               t.bz = t.az + 16'($urandom_range(0, 2 * base) - base);
               t.cx = t.ax + 16'($urandom_range(0, 2 * base) - base);
               t.cy = t.ay + 16'($urandom_range(0, 2 * base) - base);
               t.cz = t.az + 16'($urandom_range(0, 2 * base) - base);
            end
            1: begin
               // Collinear corners give a degenerate face.
               base = $urandom_range(0, 4) - 2;
               t.bx = pick_coord(); t.by_coord = t.ay; t.bz = t.az;
               t.cx = t.bx; t.cy = t.ay; t.cz = t.az;
               if (base > 0) begin
                  t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
               end
            end
            default: begin
               t.bx = pick_coord(); t.by_coord = pick_coord(); t.bz = pick_coord();
               t.cx = pick_coord(); t.cy = pick_coord(); t.cz = pick_coord();
            end
         endcase
         add_triangle(t);
      end
      stimulus_done = 1'b1;
   end

   // Driver: presents queued triangles with a random gap before each one.
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= $urandom_range(0, 10);
      end else if (req_valid && !req_stall) begin
         // The beat was taken; a gap of zero presents the next one at once.
         normal_queue = {normal_queue, face_normal(req_data)};
         gap = $urandom_range(0, 10);
         if (gap == 0 && triangle_queue.size() > 0) begin
            req_data  <= triangle_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            send_wait <= (gap > 0) ? gap - 1 : 0;
         end
      end else if (!req_valid) begin
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
         end else if (triangle_queue.size() > 0) begin
            req_data  <= triangle_queue.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Monitor: random back pressure on rsp_ and in-order checking.
   always @(posedge clock) begin
      tun_rsp_type want;
      int          hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (normal_queue.size() == 0) begin
               $display("%0t: result beat with none expected, actual %h", $time,
                        rsp_data);
               error_count++;
            end else begin
               want = normal_queue.pop_front();
               if (rsp_data.norm_x !== want.norm_x)
                  $display("%0t: norm_x expected %0d actual %0d", $time,
                           want.norm_x, rsp_data.norm_x);
               if (rsp_data.norm_y !== want.norm_y)
                  $display("%0t: norm_y expected %0d actual %0d", $time,
                           want.norm_y, rsp_data.norm_y);
               if (rsp_data.norm_z !== want.norm_z)
                  $display("%0t: norm_z expected %0d actual %0d", $time,
                           want.norm_z, rsp_data.norm_z);
               if (rsp_data.degenerate !== want.degenerate)
                  $display("%0t: degenerate expected %0b actual %0b", $time,
                           want.degenerate, rsp_data.degenerate);
               if (rsp_data !== want) error_count++;
            end
            // A fresh stall length is drawn for each result beat.
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            rsp_stall <= (hold != 0);
            recv_wait <= (hold != 0) ? hold - 1 : 0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      error_count   = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (!(stimulus_done && triangle_queue.size() == 0 && !req_valid &&
               normal_queue.size() == 0) && idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
      end else begin
         // Let any stray beat surface before the verdict.
         repeat (2 * LATENCY) @(posedge clock);
         if (error_count == 0 && normal_queue.size() == 0)
            $display("== PASS ==");
         else
            $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tun_pkg.sv
rtl/core/tun_cross.sv
rtl/core/tun_norm.sv
rtl/core/tun_sqrt.sv
rtl/core/tun_div.sv
rtl/core/triangle_unit_normal.sv
bench/triangle_unit_normal_test.sv
